@@ design/wgm_pkg.sv @@
// Shared types and constants for the weighted glyph matcher.
// Holds the request codes, the controller states, the weight table and the
// command/status structs between controller and datapath. No dependencies.
package wgm_pkg;

   // Default sizing of the glyph table and of one stored feature.
   localparam int DEF_TABLE_DEPTH  = 128;
   localparam int DEF_FEATURE_BITS = 8;

   // Fixed field widths of the stream payloads.
   localparam int NFEAT      = 9;
   localparam int FEAT_IN_W  = 8;
   localparam int INDEX_W    = 7;
   localparam int CODE_W     = 8;
   localparam int SCORE_W    = 15;
   localparam int COUNT_W    = 8;
   localparam int WEIGHT_W   = 6;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 24;

   // Result for an empty table: a space and the largest score.
   localparam logic [CODE_W-1:0]  EMPTY_CODE = 8'd32;
   localparam logic [SCORE_W-1:0] SCORE_MAX  = 15'h7FFF;

   // Region weights in row-major 3x3 order.
   localparam logic [WEIGHT_W-1:0] FEAT_WEIGHT [NFEAT] = '{
      6'd6,  6'd12, 6'd6,
      6'd12, 6'd48, 6'd12,
      6'd6,  6'd12, 6'd6
   };

   // Request kinds carried on tuser.
   typedef enum logic {
      FUNC_LOAD  = 1'b0,
      FUNC_QUERY = 1'b1
   } func_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_wr;    // write the request into the table
      logic q_capture;  // latch query features, clear pointer and best
      logic rd_en;      // read the entry at the scan pointer
      logic out_load;   // move the best match into the response register
   } wgm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic count_zero; // no entries to search
      logic last_rd;    // the pointer is at the last entry to search
      logic pipe_busy;  // reads or scores still in flight
      logic out_free;   // the response register can take a new result
   } wgm_status_type;

endpackage

@@ design/wgm_ctrl.sv @@
// Controller state machine for the weighted glyph matcher.
// Sequences load, scan, drain and result hand-off; uses wgm_pkg.
module wgm_ctrl
   import wgm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic           req_tuser,
   input  wgm_status_type status,
   output wgm_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == FUNC_QUERY) begin
                  cmd.q_capture = 1'b1;
                  state_in      = status.count_zero ? ST_DRAIN : ST_SCAN;
               end else begin
                  cmd.load_wr = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            if (status.last_rd) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // Wait until the last score is folded in and the output has room.
            if (!status.pipe_busy && status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ design/wgm_datapath.sv @@
// Datapath of the weighted glyph matcher: glyph table memory, scan pointer,
// weighted distance stage, best-match tracking and response register.
// Uses wgm_pkg; driven by wgm_ctrl through command and status structs.
module wgm_datapath
   import wgm_pkg::*;
#(
   parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
   parameter int FEATURE_BITS = DEF_FEATURE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [COUNT_W-1:0]    csr_wr_data,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  wgm_cmd_type           cmd,
   output wgm_status_type        status,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int ROW_W = CODE_W + NFEAT * FEATURE_BITS;
   localparam int SUM_W = FEATURE_BITS + 8;

   // Request fields.
   logic [INDEX_W-1:0] req_index;
   logic [CODE_W-1:0]  req_code;
   logic [ROW_W-1:0]   req_row;

   assign req_index = req_tdata[INDEX_W-1:0];
   assign req_code  = req_tdata[INDEX_W +: CODE_W];

   always_comb begin
      req_row[CODE_W-1:0] = req_code;
      for (int k = 0; k < NFEAT; k++) begin
         req_row[CODE_W + k*FEATURE_BITS +: FEATURE_BITS] =
            FEATURE_BITS'(req_tdata[INDEX_W + CODE_W + k*FEAT_IN_W +: FEAT_IN_W]);
      end
   end

   // Entry count register and its clamp to the table depth.
   logic [COUNT_W-1:0] count_ff;
   logic [CNT_W-1:0]   count_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   assign count_sat = (32'(count_ff) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : CNT_W'(count_ff);

   // Glyph table: one row per entry, code in the low bits, features above.
   logic [ROW_W-1:0] table_mem [TABLE_DEPTH];
   logic [ROW_W-1:0] rd_row_ff;
   logic [CNT_W-1:0] ptr_ff;
   logic             rd_vld_ff;
   logic             rd_first_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_wr && (32'(req_index) < TABLE_DEPTH)) begin
         table_mem[IDX_W'(req_index)] <= req_row;
      end
      if (cmd.rd_en) begin
         rd_row_ff <= table_mem[ptr_ff[IDX_W-1:0]];
      end
   end

   // Scan pointer and read-stage valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff      <= '0;
         rd_vld_ff   <= 1'b0;
         rd_first_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= cmd.rd_en;
         rd_first_ff <= cmd.rd_en && (ptr_ff == '0);
         if (cmd.q_capture) begin
            ptr_ff <= '0;
         end else if (cmd.rd_en) begin
            ptr_ff <= ptr_ff + 1'b1;
         end
      end
   end

   // Query features held for the whole scan.
   logic [FEATURE_BITS-1:0] q_ff [NFEAT];

   always_ff @(posedge clock) begin
      if (cmd.q_capture) begin
         for (int k = 0; k < NFEAT; k++) begin
            q_ff[k] <= req_row[CODE_W + k*FEATURE_BITS +: FEATURE_BITS];
         end
      end
   end

   // Weighted sum of absolute differences for the entry just read.
   logic [SUM_W-1:0]   sum;
   logic [SCORE_W-1:0] score;

   always_comb begin
      logic [FEATURE_BITS-1:0] t;
      logic [FEATURE_BITS-1:0] d;
      sum = '0;
      for (int k = 0; k < NFEAT; k++) begin
         t   = rd_row_ff[CODE_W + k*FEATURE_BITS +: FEATURE_BITS];
         d   = (q_ff[k] > t) ? (q_ff[k] - t) : (t - q_ff[k]);
         sum = sum + SUM_W'(d) * SUM_W'(FEAT_WEIGHT[k]);
      end
   end

   assign score = (32'(sum) > 32'(SCORE_MAX)) ? SCORE_MAX : SCORE_W'(sum);

   // Score stage.
   logic [SCORE_W-1:0] sc_ff;
   logic [CODE_W-1:0]  sc_code_ff;
   logic               sc_vld_ff;
   logic               sc_first_ff;

   always_ff @(posedge clock) begin
      sc_ff      <= score;
      sc_code_ff <= rd_row_ff[CODE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_vld_ff   <= 1'b0;
         sc_first_ff <= 1'b0;
      end else begin
         sc_vld_ff   <= rd_vld_ff;
         sc_first_ff <= rd_first_ff;
      end
   end

   // Best match so far; the first entry always wins, later ones only if lower.
   logic [CODE_W-1:0]  best_code_ff;
   logic [SCORE_W-1:0] best_score_ff;

   always_ff @(posedge clock) begin
      if (cmd.q_capture) begin
         best_code_ff  <= EMPTY_CODE;
         best_score_ff <= SCORE_MAX;
      end else if (sc_vld_ff && (sc_first_ff || (sc_ff < best_score_ff))) begin
         best_code_ff  <= sc_code_ff;
         best_score_ff <= sc_ff;
      end
   end

   // Response register.
   logic               rsp_vld_ff;
   logic [CODE_W-1:0]  rsp_code_ff;
   logic [SCORE_W-1:0] rsp_score_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_code_ff  <= best_code_ff;
         rsp_score_ff <= best_score_ff;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {1'b0, rsp_score_ff, rsp_code_ff};

   // Status back to the controller.
   assign status.count_zero = (count_ff == '0);
   assign status.last_rd    = ((ptr_ff + 1'b1) == count_sat);
   assign status.pipe_busy  = rd_vld_ff || sc_vld_ff;
   assign status.out_free   = !rsp_vld_ff || rsp_tready;

endmodule

@@ design/weighted_glyph_matcher_unit.sv @@
// Top level of the weighted glyph matcher.
// Joins wgm_ctrl and wgm_datapath; uses wgm_pkg.
//
// Usage: requests arrive on the req_ stream. tuser selects load (0) or query (1).
// A load writes one table entry (code and nine features) in the accepting cycle
// and gives no response; loads to a slot at or beyond the table depth are dropped.
// A query scans entries 0 to min(entry_count, depth)-1, one memory read per cycle from the
// single-port glyph table, and returns the code and weighted L1 score of the
// first lowest-scoring entry on the rsp_ stream (space and 32767 when empty).
// Sequence: an accepted query reads the entries in ST_SCAN (skipped when entry_count is 0),
// then waits in ST_DRAIN until the read and score stages are empty and the response
// register is free, loads the result there and returns to ST_IDLE to take the next request.
// A load stays in ST_IDLE, so loads follow back to back. One request is worked on at a time.
// The response sits in an output register: while the receiver stalls, the
// block still takes and finishes loads and the next query, which then waits
// before hand-off until the register is free.
// The user must write entry_count on the csr_ port only while idle; the block does not
// enforce this. Reset clears entry_count and all control state; the table is unknown until loaded.
module weighted_glyph_matcher_unit
   import wgm_pkg::*;
#(
   parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
   parameter int FEATURE_BITS = DEF_FEATURE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   // Configuration write of entry_count.
   input  logic                  csr_wr_en,
   input  logic [COUNT_W-1:0]    csr_wr_data,
   // Request stream.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tuser,   // func
   // Low to high: entry_index[6:0], glyph_code[14:7], feat_top_left[22:15],
   // feat_top[30:23], feat_top_right[38:31], feat_left[46:39],
   // feat_center[54:47], feat_right[62:55], feat_bottom_left[70:63],
   // feat_bottom[78:71], feat_bottom_right[86:79], zero pad [87].
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // Response stream.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // Low to high: match_code[7:0], match_score[22:8], zero pad [23].
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   wgm_cmd_type    cmd;
   wgm_status_type status;

   // Sequencer.
   wgm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   // Table, scoring and result registers.
   wgm_datapath #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .FEATURE_BITS (FEATURE_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .cmd         (cmd),
      .status      (status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
